[src/hvn_pkg.sv]
// ----------------------------------------------------------------------------
// hvn_pkg: shared types and constants for the vertex normal unit
// Face table, fixed-point constants and the normalizer status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hvn_pkg;

    localparam int ACC_W     = 18;     // sum of up to six Q1.14 components
    localparam int LIM_W     = 11;     // grid limits up to 1024
    localparam int ONE_Q14   = 16384;
    localparam int FRAC_SH   = 28;
    localparam int QUOT_W    = 18;
    localparam int NUM_FACES = 6;

    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_SPACING   = 2'd2;

    localparam logic signed [1:0] OFS_P = 2'sb01;
    localparam logic signed [1:0] OFS_Z = 2'sb00;
    localparam logic signed [1:0] OFS_M = 2'sb11;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_stat_t;

    // Corner offsets of one adjacent triangle, its cross product form and
    // the neighbors it needs (down, up, left, right).
    typedef struct packed {
        logic signed [1:0] dr0;
        logic signed [1:0] dc0;
        logic signed [1:0] dr1;
        logic signed [1:0] dc1;
        logic signed [1:0] dr2;
        logic signed [1:0] dc2;
        logic              type_b;
        logic              need_dn;
        logic              need_up;
        logic              need_lf;
        logic              need_rt;
    } face_t;

    // Type A: n = (-ah, s, -bh). Type B: n = (-ah, s, bh - ah).
    localparam face_t FACES [NUM_FACES] = '{
        '{OFS_Z, OFS_Z, OFS_Z, OFS_P, OFS_P, OFS_Z, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{OFS_Z, OFS_M, OFS_Z, OFS_Z, OFS_P, OFS_M, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        '{OFS_P, OFS_M, OFS_P, OFS_Z, OFS_Z, OFS_Z, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
        '{OFS_M, OFS_Z, OFS_M, OFS_P, OFS_Z, OFS_Z, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1},
        '{OFS_Z, OFS_Z, OFS_Z, OFS_P, OFS_M, OFS_P, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1},
        '{OFS_Z, OFS_M, OFS_Z, OFS_Z, OFS_M, OFS_Z, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}
    };

endpackage

`default_nettype wire

[src/hvn_store.sv]
// ----------------------------------------------------------------------------
// hvn_store: height memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_store #(
    parameter int DEPTH  = 4096,
    parameter int AW     = 12,
    parameter int DATA_W = 16
)(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/hvn_norm.sv]
// ----------------------------------------------------------------------------
// hvn_norm: shared vector normalizer
// Squares the three components in turn, bit-serial integer root, then three
// restoring divides with rounding and clamping to Q1.14; a zero vector is flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_norm
    import hvn_pkg::*;
#(
    parameter int CW = 18
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    input  logic signed [CW-1:0] vec_z,
    output norm_stat_t           stat,
    output logic signed [15:0]   unit_x,
    output logic signed [15:0]   unit_y,
    output logic signed [15:0]   unit_z
);

    localparam int QW   = CW + 15;
    localparam int RW   = 2 * QW;
    localparam int L2W  = 2 * CW + 2;
    localparam int DW   = CW + 33;
    localparam int CNTW = $clog2(QW + 1);

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SQ    = 7'b0000010,
        N_CHK   = 7'b0000100,
        N_ROOT  = 7'b0001000,
        N_DSET  = 7'b0010000,
        N_DSTEP = 7'b0100000,
        N_DFIN  = 7'b1000000
    } norm_state_t;

    norm_state_t state_reg, state_next;
    logic signed [CW-1:0] vx_reg, vy_reg, vz_reg, vx_next, vy_next, vz_next;
    logic [1:0]           cidx_reg, cidx_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [L2W-1:0]       l2_reg, l2_next;
    logic [RW-1:0]        rad_reg, rad_next;
    logic [QW+1:0]        rem_reg, rem_next;
    logic [QW-1:0]        root_reg, root_next;
    logic [DW-1:0]        drem_reg, drem_next, div_reg, div_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic signed [15:0]   ux_reg, uy_reg, uz_reg, ux_next, uy_next, uz_next;
    logic                 done_reg, done_next, zero_reg, zero_next;

    logic signed [CW-1:0] sel_comp;
    logic [CW-1:0]        sel_mag;
    logic [2*CW-1:0]      sq;
    logic [QW+3:0]        rem_sh, trial;
    logic                 root_ge, div_ge;
    logic [15:0]          mag16;
    logic signed [15:0]   res16;
    logic [DW-1:0]        num;

    always_comb
    begin
        case (cidx_reg)
            2'd0:    sel_comp = vx_reg;
            2'd1:    sel_comp = vy_reg;
            default: sel_comp = vz_reg;
        endcase
        sel_mag = sel_comp[CW-1] ? CW'(-sel_comp) : CW'(sel_comp);
        sq      = sel_mag * sel_mag;
        rem_sh  = {rem_reg, rad_reg[RW-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = rem_sh >= trial;
        div_ge  = drem_reg >= div_reg;
        mag16   = (quot_reg > QUOT_W'(ONE_Q14)) ? 16'(ONE_Q14) : quot_reg[15:0];
        res16   = sel_comp[CW-1] ? -$signed(mag16) : $signed(mag16);
        num     = (DW'(sel_mag) << FRAC_SH) + DW'(root_reg >> 1);
    end

    always_comb
    begin
        state_next = state_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        vz_next    = vz_reg;
        cidx_next  = cidx_reg;
        cnt_next   = cnt_reg;
        l2_next    = l2_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        drem_next  = drem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        uz_next    = uz_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    vx_next    = vec_x;
                    vy_next    = vec_y;
                    vz_next    = vec_z;
                    l2_next    = '0;
                    cidx_next  = 2'd0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                l2_next = l2_reg + L2W'(sq);
                if (cidx_reg == 2'd2)
                begin
                    cidx_next  = 2'd0;
                    state_next = N_CHK;
                end
                else
                begin
                    cidx_next = cidx_reg + 2'd1;
                end
            end
            N_CHK:
            begin
                if (l2_reg == '0)
                begin
                    zero_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = N_IDLE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    rad_next   = {l2_reg, FRAC_SH'(0)};
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = N_ROOT;
                end
            end
            N_ROOT:
            begin
                // two radicand bits per step
                rad_next  = rad_reg << 2;
                rem_next  = root_ge ? (QW+2)'(rem_sh - trial) : (QW+2)'(rem_sh);
                root_next = {root_reg[QW-2:0], root_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    state_next = N_DSET;
                end
            end
            N_DSET:
            begin
                drem_next  = num;
                div_next   = DW'(root_reg) << (QUOT_W - 1);
                quot_next  = '0;
                cnt_next   = '0;
                state_next = N_DSTEP;
            end
            N_DSTEP:
            begin
                if (div_ge)
                begin
                    drem_next = drem_reg - div_reg;
                end
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                div_next  = div_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QUOT_W - 1))
                begin
                    state_next = N_DFIN;
                end
            end
            N_DFIN:
            begin
                case (cidx_reg)
                    2'd0:    ux_next = res16;
                    2'd1:    uy_next = res16;
                    default: uz_next = res16;
                endcase
                if (cidx_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = N_IDLE;
                end
                else
                begin
                    cidx_next  = cidx_reg + 2'd1;
                    state_next = N_DSET;
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        vz_reg   <= vz_next;
        cidx_reg <= cidx_next;
        cnt_reg  <= cnt_next;
        l2_reg   <= l2_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        drem_reg <= drem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        uz_reg   <= uz_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = zero_reg;
    assign unit_x    = ux_reg;
    assign unit_y    = uy_reg;
    assign unit_z    = uz_reg;

endmodule

`default_nettype wire

[src/heightmap_vertex_normals.sv]
// ----------------------------------------------------------------------------
// heightmap_vertex_normals: smoothed vertex normals of a height grid
//
// Input beats on the s_ group carry a height write or a normal query (s_tuser
// tells which); each query yields one result beat on the m_ group, a write
// yields none. A query runs up to six face normalizations and a final one on
// a single shared normalizer. A normalization runs three squares, a zero
// check that ends at once for a zero vector, 33 root steps, three divides
// and a hand-back step. Each face is first picked and its three heights
// read; faces that fall off the grid are skipped. Out-of-range queries and
// zero spacing bypass the normalizer. s_tready is high only while no query
// is in flight. A finished result sits in the output register until taken;
// a following query may start meanwhile and holds its own result until the
// output register frees up.
// Reset clears the control state and sets 64 x 64 rows/columns and spacing
// 1.0; the height memory is not cleared, so read a vertex only after writing
// it. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_vertex_normals
    import hvn_pkg::*;
#(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int HEIGHT_BITS = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[5:0], col[5:0], height[15:0], zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x[15:0], normal_y[14:0], normal_z[15:0], zero pad
    output logic        m_tuser,   // bad_index
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (HEIGHT_BITS + 2 > 18) ? HEIGHT_BITS + 2 : 18;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_SCAN    = 8'b00000010,
        S_READ    = 8'b00000100,
        S_FACE    = 8'b00001000,
        S_FWAIT   = 8'b00010000,
        S_FINAL   = 8'b00100000,
        S_FINWAIT = 8'b01000000,
        S_PUSH    = 8'b10000000
    } seq_state_t;

    typedef struct packed {
        logic dn;
        logic up;
        logic lf;
        logic rt;
    } nbr_t;

    seq_state_t state_reg, state_next;
    logic [6:0]  grid_rows_reg, grid_rows_next, grid_cols_reg, grid_cols_next;
    logic [15:0] spacing_reg, spacing_next;
    logic        out_valid_reg, out_valid_next;

    logic [5:0]  row_reg, row_next, col_reg, col_next;
    nbr_t        nbr_reg, nbr_next;
    logic [2:0]  face_reg, face_next;
    logic [1:0]  p_reg, p_next;
    logic signed [HEIGHT_BITS-1:0] h1_reg, h2_reg, h3_reg, h1_next, h2_next, h3_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [ACC_W-1:0] acc_x_next, acc_y_next, acc_z_next;
    logic signed [15:0] res_x_reg, res_z_reg, res_x_next, res_z_next;
    logic [14:0]        res_y_reg, res_y_next;
    logic               res_bad_reg, res_bad_next;
    logic signed [15:0] out_x_reg, out_z_reg, out_x_next, out_z_next;
    logic [14:0]        out_y_reg, out_y_next;
    logic               out_bad_reg, out_bad_next;

    logic        in_cmd;
    logic [5:0]  in_row, in_col;
    logic [15:0] in_height;
    logic        accept;
    logic [LIM_W-1:0] rows_lim, cols_lim, row_ext, col_ext;
    logic        bad_q, wr_ok;
    nbr_t        nbr_q;
    logic [31:0] hext;

    face_t             fe;
    logic              face_ok;
    logic signed [1:0] dr, dc;
    logic [6:0]        prow, pcol;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [HEIGHT_BITS-1:0] rdata;

    logic signed [CW-1:0] he1, he2, he3, ah, bh, fx, fz;
    logic                 norm_start;
    logic signed [CW-1:0] nvx, nvy, nvz;
    norm_stat_t           nstat;
    logic signed [15:0]   unit_x, unit_y, unit_z;

    assign in_cmd    = s_tuser;
    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_height = s_tdata[27:12];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Grid limits clamped to [2, MAX]; neighbor availability of the query.
    always_comb
    begin
        rows_lim = LIM_W'(grid_rows_reg);
        if (rows_lim < LIM_W'(2))
            rows_lim = LIM_W'(2);
        else if (rows_lim > LIM_W'(MAX_ROWS))
            rows_lim = LIM_W'(MAX_ROWS);
        cols_lim = LIM_W'(grid_cols_reg);
        if (cols_lim < LIM_W'(2))
            cols_lim = LIM_W'(2);
        else if (cols_lim > LIM_W'(MAX_COLS))
            cols_lim = LIM_W'(MAX_COLS);
        row_ext   = LIM_W'(in_row);
        col_ext   = LIM_W'(in_col);
        bad_q     = (row_ext >= rows_lim) || (col_ext >= cols_lim);
        nbr_q.dn  = (row_ext + LIM_W'(1)) < rows_lim;
        nbr_q.up  = (in_row != 6'd0);
        nbr_q.rt  = (col_ext + LIM_W'(1)) < cols_lim;
        nbr_q.lf  = (in_col != 6'd0);
        wr_ok     = (row_ext < LIM_W'(MAX_ROWS)) && (col_ext < LIM_W'(MAX_COLS));
        hext      = {{16{in_height[15]}}, in_height};
    end

    assign we    = accept && !in_cmd && wr_ok;
    assign waddr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);

    // Corner address of the current face
    always_comb
    begin
        fe      = FACES[face_reg];
        face_ok = (!fe.need_dn || nbr_reg.dn) && (!fe.need_up || nbr_reg.up) &&
                  (!fe.need_lf || nbr_reg.lf) && (!fe.need_rt || nbr_reg.rt);
        case (p_reg)
            2'd0:
            begin
                dr = fe.dr0;
                dc = fe.dc0;
            end
            2'd1:
            begin
                dr = fe.dr1;
                dc = fe.dc1;
            end
            default:
            begin
                dr = fe.dr2;
                dc = fe.dc2;
            end
        endcase
        prow  = {1'b0, row_reg} + {{5{dr[1]}}, dr};
        pcol  = {1'b0, col_reg} + {{5{dc[1]}}, dc};
        raddr = AW'(prow) * AW'(MAX_COLS) + AW'(pcol);
    end

    hvn_store #(
        .DEPTH  (DEPTH),
        .AW     (AW),
        .DATA_W (HEIGHT_BITS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (hext[HEIGHT_BITS-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Face normal scaled down by spacing, or the accumulated sum for the final pass
    always_comb
    begin
        he1 = CW'(h1_reg);
        he2 = CW'(h2_reg);
        he3 = CW'(h3_reg);
        ah  = he2 - he1;
        bh  = he3 - he1;
        fx  = -ah;
        fz  = fe.type_b ? (bh - ah) : -bh;
        norm_start = (state_reg == S_FACE) || (state_reg == S_FINAL);
        if (state_reg == S_FINAL)
        begin
            nvx = CW'(acc_x_reg);
            nvy = CW'(acc_y_reg);
            nvz = CW'(acc_z_reg);
        end
        else
        begin
            nvx = fx;
            nvy = CW'(spacing_reg);
            nvz = fz;
        end
    end

    hvn_norm #(
        .CW (CW)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec_x  (nvx),
        .vec_y  (nvy),
        .vec_z  (nvz),
        .stat   (nstat),
        .unit_x (unit_x),
        .unit_y (unit_y),
        .unit_z (unit_z)
    );

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        spacing_next   = spacing_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_ROWS: grid_rows_next = cfg_data[6:0];
                REG_GRID_COLS: grid_cols_next = cfg_data[6:0];
                REG_SPACING:   spacing_next   = cfg_data;
                default:       spacing_next   = spacing_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        row_next       = row_reg;
        col_next       = col_reg;
        nbr_next       = nbr_reg;
        face_next      = face_reg;
        p_next         = p_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        h3_next        = h3_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_z_next     = acc_z_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_z_next     = res_z_reg;
        res_bad_next   = res_bad_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_bad_next   = out_bad_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_cmd)
                begin
                    row_next   = in_row;
                    col_next   = in_col;
                    nbr_next   = nbr_q;
                    face_next  = 3'd0;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    acc_z_next = '0;
                    if (bad_q)
                    begin
                        res_x_next   = '0;
                        res_y_next   = '0;
                        res_z_next   = '0;
                        res_bad_next = 1'b1;
                        state_next   = S_PUSH;
                    end
                    else if (spacing_reg == 16'd0)
                    begin
                        res_x_next   = '0;
                        res_y_next   = 15'(ONE_Q14);
                        res_z_next   = '0;
                        res_bad_next = 1'b0;
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // skip faces that fall off the grid
                if (face_ok)
                begin
                    p_next     = 2'd0;
                    state_next = S_READ;
                end
                else if (face_reg == 3'(NUM_FACES - 1))
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    face_next = face_reg + 3'd1;
                end
            end
            S_READ:
            begin
                p_next = p_reg + 2'd1;
                case (p_reg)
                    2'd1:    h1_next = rdata;
                    2'd2:    h2_next = rdata;
                    2'd3:    h3_next = rdata;
                    default: h1_next = h1_reg;
                endcase
                if (p_reg == 2'd3)
                begin
                    state_next = S_FACE;
                end
            end
            S_FACE:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (nstat.done)
                begin
                    acc_x_next = acc_x_reg + ACC_W'(unit_x);
                    acc_y_next = acc_y_reg + ACC_W'(unit_y);
                    acc_z_next = acc_z_reg + ACC_W'(unit_z);
                    if (face_reg == 3'(NUM_FACES - 1))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        face_next  = face_reg + 3'd1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_FINAL:
            begin
                state_next = S_FINWAIT;
            end
            S_FINWAIT:
            begin
                if (nstat.done)
                begin
                    res_bad_next = 1'b0;
                    if (nstat.zero)
                    begin
                        res_x_next = '0;
                        res_y_next = 15'(ONE_Q14);
                        res_z_next = '0;
                    end
                    else
                    begin
                        res_x_next = unit_x;
                        res_y_next = unit_y[14:0];
                        res_z_next = unit_z;
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || m_tready)
                begin
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_z_next     = res_z_reg;
                    out_bad_next   = res_bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            grid_rows_reg <= 7'd64;
            grid_cols_reg <= 7'd64;
            spacing_reg   <= 16'd256;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            spacing_reg   <= spacing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        nbr_reg     <= nbr_next;
        face_reg    <= face_next;
        p_reg       <= p_next;
        h1_reg      <= h1_next;
        h2_reg      <= h2_next;
        h3_reg      <= h3_next;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        acc_z_reg   <= acc_z_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_z_reg   <= res_z_next;
        res_bad_reg <= res_bad_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        out_bad_reg <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_bad_reg;

endmodule

`default_nettype wire
